/* hw/rtl/c2d_pkg.sv */
// shared types and constants for the sliding-window convolution block
package c2d_pkg;

  localparam int PIX_W = 16;
  localparam int WGT_W = 16;
  localparam int SUM_W = 40;
  localparam int POS_W = 10;
  localparam int WIDX_W = 6;
  localparam int SIZE_W = 11;
  localparam int RAD_W = 2;
  localparam int PROD_W = PIX_W + WGT_W + 1;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;
  localparam logic [0:0] REG_KERNEL_RADIUS = 1'b1;

  // classified item passed from the front end to the compute back end
  // wgt marks a kernel weight write that travels in order with the pixels
  typedef struct packed {
    logic                    emit;
    logic                    last;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    wgt;
    logic [WIDX_W-1:0]       widx;
    logic [WGT_W-1:0]        wval;
  } c2d_tag_t;

endpackage

/* hw/rtl/c2d_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/c2d_front.sv */
// front end: counters, line buffers and sliding window, classifies each pixel
module c2d_front #(
  parameter int MAX_IMAGE = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  command,
  input  logic [c2d_pkg::WIDX_W-1:0]            weight_index,
  input  logic [c2d_pkg::WGT_W-1:0]             weight_value,
  input  logic [c2d_pkg::PIX_W-1:0]             pixel_value,
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [c2d_pkg::SIZE_W-1:0]            cfg_data,
  output logic [$clog2(MAX_KERNEL+1)-1:0]       side,
  output logic                                  push,
  output c2d_pkg::c2d_tag_t                     push_tag,
  output logic [MAX_KERNEL*MAX_KERNEL*c2d_pkg::PIX_W-1:0] push_win,
  input  logic                                  q_ready
);

  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int CW = $clog2(MAX_IMAGE + 1);
  localparam int AW = $clog2(MAX_IMAGE);
  localparam int SW = $clog2(MAX_KERNEL + 1);
  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int RMAX = (MAX_KERNEL - 1) / 2;
  localparam int PW = c2d_pkg::PIX_W;

  logic [c2d_pkg::SIZE_W-1:0] image_size;
  logic [c2d_pkg::RAD_W-1:0]  kernel_radius;
  logic [CW-1:0] n_eff;
  logic [c2d_pkg::RAD_W-1:0] rad;
  logic [CW-1:0] row_count, col_count, row_next, col_next;
  logic [LW-1:0] slot_base, slot_base_next;

  // stage 1: pixel registered while line buffers are read
  logic            s1_valid;
  logic [PW-1:0]   s1_pix;
  logic [CW-1:0]   s1_r, s1_c;
  logic [LW-1:0]   s1_slot;
  logic            s1_wgt;
  logic [c2d_pkg::WIDX_W-1:0] s1_widx;
  logic [c2d_pkg::WGT_W-1:0]  s1_wval;
  logic [PW-1:0]   rd [LINES];
  logic [PW-1:0]   win [MAX_KERNEL][MAX_KERNEL];
  logic [PW-1:0]   colv [MAX_KERNEL];
  logic            out_valid;

  always_comb begin
    n_eff = CW'(image_size);
    if (image_size == '0) n_eff = CW'(1);
    if ({1'b0, image_size} > (c2d_pkg::SIZE_W+1)'(MAX_IMAGE)) n_eff = CW'(MAX_IMAGE);
    rad = (int'(kernel_radius) > RMAX) ? c2d_pkg::RAD_W'(RMAX) : kernel_radius;
  end
  assign side = SW'({rad, 1'b1});

  assign in_ready = q_ready;
  wire acc = in_valid && in_ready;
  wire pix = acc && (command == c2d_pkg::CMD_PIXEL);
  // weight writes follow the pixels down the pipe so earlier pixels keep old weights
  wire wld = acc && (command == c2d_pkg::CMD_WEIGHT)
             && (int'(weight_index) < MAX_KERNEL*MAX_KERNEL);

  always_comb begin
    col_next = col_count + CW'(1);
    row_next = row_count;
    slot_base_next = slot_base;
    if (col_next >= n_eff) begin
      col_next = '0;
      row_next = row_count + CW'(1);
      slot_base_next = (int'(slot_base) == LINES-1) ? '0 : slot_base + LW'(1);
      if (row_next >= n_eff) begin
        row_next = '0;
        slot_base_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= c2d_pkg::SIZE_W'(1024);
      kernel_radius <= c2d_pkg::RAD_W'(1);
      row_count <= '0;
      col_count <= '0;
      slot_base <= '0;
      s1_valid <= 1'b0;
      s1_wgt <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == c2d_pkg::REG_IMAGE_SIZE) image_size <= cfg_data;
        else kernel_radius <= cfg_data[c2d_pkg::RAD_W-1:0];
        row_count <= '0;
        col_count <= '0;
        slot_base <= '0;
      end else if (pix) begin
        row_count <= row_next;
        col_count <= col_next;
        slot_base <= slot_base_next;
      end
      if (q_ready) begin
        s1_valid <= pix;
        s1_wgt <= wld;
        out_valid <= s1_valid || s1_wgt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && pix) begin
      s1_pix <= pixel_value;
      s1_r <= row_count;
      s1_c <= col_count;
      s1_slot <= slot_base;
    end
    if (wld) begin
      s1_widx <= weight_index;
      s1_wval <= weight_value;
    end
  end

  // line buffers: line j holds row r with r mod LINES == j
  for (genvar j = 0; j < LINES; j++) begin : g_line
    c2d_ram #(.WIDTH(PW), .DEPTH(MAX_IMAGE)) u_line (
      .clk  (clk),
      .we   (q_ready && s1_valid && (int'(s1_slot) == j) && (MAX_KERNEL > 1)),
      .waddr(AW'(s1_c)),
      .wdata(s1_pix),
      .re   (q_ready && pix),
      .raddr(AW'(col_count)),
      .rdata(rd[j])
    );
  end

  // column entering on the right: row k of window (k = side-1 is newest)
  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++) begin
      int d, s;
      d = int'(side) - 1 - k;
      s = int'(s1_slot) - d;
      // d never exceeds LINES, so one wrap is enough
      if (s < 0) s = s + LINES;
      if (k >= int'(side)) colv[k] = '0;
      else if (d == 0) colv[k] = s1_pix;
      else colv[k] = rd[LW'(s)];
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && s1_valid) begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
        for (int j = 0; j < MAX_KERNEL-1; j++) win[k][j] <= win[k][j+1];
        win[k][MAX_KERNEL-1] <= colv[k];
      end
      push_tag.emit <= (s1_r + CW'(1) >= CW'(side)) && (s1_c + CW'(1) >= CW'(side));
      push_tag.last <= (s1_r == n_eff - CW'(1)) && (s1_c == n_eff - CW'(1));
      push_tag.row <= c2d_pkg::POS_W'(s1_r - CW'(rad));
      push_tag.col <= c2d_pkg::POS_W'(s1_c - CW'(rad));
      push_tag.wgt <= 1'b0;
    end else if (q_ready && s1_wgt) begin
      push_tag.emit <= 1'b0;
      push_tag.last <= 1'b0;
      push_tag.wgt <= 1'b1;
      push_tag.widx <= s1_widx;
      push_tag.wval <= s1_wval;
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_KERNEL; k++)
      for (int j = 0; j < MAX_KERNEL; j++)
        push_win[(k*MAX_KERNEL+j)*PW +: PW] = win[k][j];
  end

  assign push = out_valid && q_ready && (push_tag.emit || push_tag.wgt);

endmodule

/* hw/rtl/c2d_back.sv */
// back end: window queue and pipelined multiply-add tree with output fifo
module c2d_back #(
  parameter int MAX_KERNEL = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(MAX_KERNEL+1)-1:0]       side,
  input  logic                                  push,
  input  c2d_pkg::c2d_tag_t                     push_tag,
  input  logic [MAX_KERNEL*MAX_KERNEL*c2d_pkg::PIX_W-1:0] push_win,
  output logic                                  q_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output c2d_pkg::c2d_tag_t                     out_tag,
  output logic signed [c2d_pkg::SUM_W-1:0]      out_sum
);

  localparam int NW = MAX_KERNEL * MAX_KERNEL;
  localparam int PW = c2d_pkg::PIX_W;
  localparam int QD = 8;
  localparam int QA = $clog2(QD);
  localparam int PIPE = 3;

  logic [c2d_pkg::WGT_W-1:0] kw [NW];
  logic [NW*PW-1:0] qwin [QD];
  c2d_pkg::c2d_tag_t qtag [QD];
  logic [QA-1:0] wp, rp;
  logic [QA:0] cnt, inflight;
  logic [PIPE-1:0] pv;
  c2d_pkg::c2d_tag_t ptag [PIPE];
  logic signed [c2d_pkg::PROD_W-1:0] prod [NW];
  logic signed [c2d_pkg::SUM_W-1:0] rsum [MAX_KERNEL];
  logic [NW*PW-1:0] cur;

  // front end stalls while queue plus pipeline could overflow
  assign q_ready = (int'(cnt) + int'(inflight)) < QD - 2;
  wire pop = (cnt != '0);
  wire head_wgt = qtag[rp].wgt;
  wire pop_px = pop && !head_wgt;
  wire fire = out_valid && out_ready;

  // weight writes take effect in queue order
  always_ff @(posedge clk) if (pop && head_wgt) kw[qtag[rp].widx] <= qtag[rp].wval;

  always_ff @(posedge clk) begin
    if (push) begin
      qwin[wp] <= push_win;
      qtag[wp] <= push_tag;
    end
  end
  assign cur = qwin[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0; pv <= '0; inflight <= '0;
    end else begin
      if (push) wp <= wp + QA'(1);
      if (pop) rp <= rp + QA'(1);
      cnt <= cnt + (QA+1)'(push) - (QA+1)'(pop);
      pv <= {pv[PIPE-2:0], pop_px};
      inflight <= inflight + (QA+1)'(pop_px) - (QA+1)'(fire);
    end
  end

  // output staging: results leave through a small fifo inside the inflight count
  c2d_pkg::c2d_tag_t otag [QD];
  logic signed [c2d_pkg::SUM_W-1:0] osum [QD];
  logic [QA-1:0] owp, orp;
  logic [QA:0] ocnt;
  logic signed [c2d_pkg::SUM_W-1:0] total, tsum;

  assign out_valid = (ocnt != '0);

  always_comb begin
    total = '0;
    for (int k = 0; k < MAX_KERNEL; k++) total = total + rsum[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0; orp <= '0; ocnt <= '0;
    end else begin
      if (pv[PIPE-1]) owp <= owp + QA'(1);
      if (fire) orp <= orp + QA'(1);
      ocnt <= ocnt + (QA+1)'(pv[PIPE-1]) - (QA+1)'(fire);
    end
    tsum <= total;
    if (pv[PIPE-1]) begin
      otag[owp] <= ptag[PIPE-1];
      osum[owp] <= tsum;
    end
  end

  assign out_tag = otag[orp];
  assign out_sum = osum[orp];

  // stage 0: products, stage 1: row sums, stage 2: window total, then output fifo
  always_ff @(posedge clk) begin
    ptag[0] <= qtag[rp];
    for (int i = 1; i < PIPE; i++) ptag[i] <= ptag[i-1];
    for (int k = 0; k < MAX_KERNEL; k++)
      for (int j = 0; j < MAX_KERNEL; j++) begin
        int base, wi;
        base = MAX_KERNEL - int'(side);
        wi = k * int'(side) + (j - base);
        if (k < int'(side) && j >= base)
          prod[k*MAX_KERNEL+j] <= $signed(cur[(k*MAX_KERNEL+j)*PW +: PW])
                                  * $signed({1'b0, kw[c2d_pkg::WIDX_W'(wi)]});
        else
          prod[k*MAX_KERNEL+j] <= '0;
      end
    for (int k = 0; k < MAX_KERNEL; k++) begin
      logic signed [c2d_pkg::SUM_W-1:0] acc;
      acc = '0;
      for (int j = 0; j < MAX_KERNEL; j++) acc = acc + c2d_pkg::SUM_W'(prod[k*MAX_KERNEL+j]);
      rsum[k] <= acc;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (int'(cnt) + int'(inflight)) <= QD)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) int'(ocnt) <= int'(inflight))
    else $error("output fifo beyond inflight count");
  assert property (@(posedge clk) disable iff (rst) !(push && int'(cnt) == QD))
    else $error("push into full queue");

endmodule

/* hw/rtl/conv2d_sliding_window.sv */
// top level of the sliding-window 2d convolution block
// path from input transaction to result transaction:
// two front stages, queue, three multiply-add stages, output fifo
// throughput: one transaction per cycle sustained while m_tready stays high, weights and pixels alike
// the multiply tree is a 3-stage pipeline fed from an 8-deep window queue
// reset: synchronous active-high rst clears counters, queue pointers and valid flags
// and sets image size 1024, radius 1; kernel weights and line buffers are undefined until written
module conv2d_sliding_window #(
  parameter int MAX_IMAGE = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // weight_index, weight_value, pixel_value, zero fill
  input  logic        s_tuser,  // command
  input  logic        m_tready,
  output logic        m_tvalid,
  output logic [63:0] m_tdata,  // out_row, out_col, out_sum, zero fill
  output logic        m_tlast,  // frame_last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  logic push, q_ready;
  logic [$clog2(MAX_KERNEL+1)-1:0] side;
  c2d_pkg::c2d_tag_t push_tag, out_tag;
  logic [MAX_KERNEL*MAX_KERNEL*c2d_pkg::PIX_W-1:0] push_win;
  logic signed [c2d_pkg::SUM_W-1:0] out_sum;

  c2d_front #(.MAX_IMAGE(MAX_IMAGE), .MAX_KERNEL(MAX_KERNEL)) u_front (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready),
    .command(s_tuser), .weight_index(s_tdata[5:0]),
    .weight_value(s_tdata[21:6]), .pixel_value(s_tdata[37:22]),
    .cfg_we, .cfg_index, .cfg_data,
    .side, .push, .push_tag, .push_win, .q_ready
  );

  c2d_back #(.MAX_KERNEL(MAX_KERNEL)) u_back (
    .clk, .rst, .side, .push, .push_tag, .push_win,
    .q_ready, .out_valid(m_tvalid), .out_ready(m_tready), .out_tag, .out_sum
  );

  assign m_tdata = {4'b0, out_sum, out_tag.col, out_tag.row};
  assign m_tlast = out_tag.last;

endmodule

/* tb/sv/conv2d_sliding_window_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the sliding-window 2d convolution block
module conv2d_sliding_window_tb;

  localparam int LINE_CNT = 6;
  localparam int IMG_MAX = 1024;
  localparam int KSIDE_MAX = 7;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [c2d_pkg::POS_W-1:0] row;
    logic [c2d_pkg::POS_W-1:0] col;
    logic [c2d_pkg::SUM_W-1:0] sum;
    logic                      last;
  } conv_result_t;

  // predicts window sums and keeps the results still owed by the block
  class conv_scoreboard;
    conv_result_t              owed_q[$];
    logic [c2d_pkg::WGT_W-1:0] kernel[KSIDE_MAX*KSIDE_MAX];
    logic [c2d_pkg::PIX_W-1:0] lines[LINE_CNT*IMG_MAX];
    logic [c2d_pkg::PIX_W-1:0] win[KSIDE_MAX*KSIDE_MAX];
    int unsigned               size_reg, rad_reg, row_cnt, col_cnt;
    int                        errors;

    function void clear();
      foreach (kernel[i]) kernel[i] = '0;
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i]) win[i] = '0;
      size_reg = 1024;
      rad_reg = 1;
      row_cnt = 0;
      col_cnt = 0;
      errors = 0;
      owed_q.delete();
    endfunction

    function void write_reg(logic [0:0] idx, logic [c2d_pkg::SIZE_W-1:0] val);
      if (idx == c2d_pkg::REG_IMAGE_SIZE) size_reg = val;
      else rad_reg = val[c2d_pkg::RAD_W-1:0];
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    // one accepted input transaction: command on top, tdata below
    function void note_input(logic [40:0] d);
      logic [c2d_pkg::WIDX_W-1:0] widx;
      logic [c2d_pkg::PIX_W-1:0]  pix;
      logic [c2d_pkg::PIX_W-1:0]  colv[KSIDE_MAX];
      int unsigned                n, rad, side, r, c, gap, slot, base;
      longint                     acc;
      conv_result_t               res;
      widx = d[5:0];
      pix = d[37:22];
      if (d[40] == c2d_pkg::CMD_WEIGHT) begin
        if (widx < KSIDE_MAX*KSIDE_MAX) kernel[widx] = d[21:6];
        return;
      end
      n = (size_reg == 0) ? 1 : (size_reg > IMG_MAX ? IMG_MAX : size_reg);
      rad = (rad_reg > (KSIDE_MAX-1)/2) ? (KSIDE_MAX-1)/2 : rad_reg;
      side = 2*rad + 1;
      r = (row_cnt >= n) ? 0 : row_cnt;
      c = (col_cnt >= n) ? 0 : col_cnt;
      // new column: rows above come from the line store, bottom is the new pixel
      for (int ki = 0; ki < side; ki++) begin
        gap = side - 1 - ki;
        if (gap == 0) colv[ki] = pix;
        else begin
          slot = ((r % LINE_CNT) + LINE_CNT - (gap % LINE_CNT)) % LINE_CNT;
          colv[ki] = lines[slot*IMG_MAX + c];
        end
      end
      lines[(r % LINE_CNT)*IMG_MAX + c] = pix;
      for (int ki = 0; ki < KSIDE_MAX; ki++) begin
        for (int kj = 0; kj < KSIDE_MAX-1; kj++)
          win[ki*KSIDE_MAX + kj] = win[ki*KSIDE_MAX + kj + 1];
        win[ki*KSIDE_MAX + KSIDE_MAX-1] = (ki < side) ? colv[ki] : '0;
      end
      if (r + 1 >= side && c + 1 >= side) begin
        acc = 0;
        base = KSIDE_MAX - side;
        for (int ki = 0; ki < side; ki++)
          for (int kj = 0; kj < side; kj++)
            acc += longint'($signed(win[ki*KSIDE_MAX + base + kj]))
                   * longint'({1'b0, kernel[ki*side + kj]});
        res.row = c2d_pkg::POS_W'(r - rad);
        res.col = c2d_pkg::POS_W'(c - rad);
        res.sum = acc[c2d_pkg::SUM_W-1:0];
        res.last = (r == n-1 && c == n-1);
        owed_q.push_back(res);
      end
      c++;
      if (c >= n) begin
        c = 0;
        r++;
        if (r >= n) r = 0;
      end
      row_cnt = r;
      col_cnt = c;
    endfunction

    function void check(conv_result_t got);
      conv_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing expected: row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.row !== want.row) begin
        $error("out_row expected %0d actual %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("out_col expected %0d actual %0d", want.col, got.col);
        errors++;
      end
      if (got.sum !== want.sum) begin
        $error("out_sum expected %0d actual %0d", $signed(want.sum), $signed(got.sum));
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_last expected %0b actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;    // weight_index, weight_value, pixel_value, zero fill
  logic        s_tuser = 1'b0;  // command
  logic        m_tready = 1'b0;
  logic        m_tvalid;
  logic [63:0] m_tdata;         // out_row, out_col, out_sum, zero fill
  logic        m_tlast;         // frame_last
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  conv_scoreboard sb;
  bit          calm;            // no random idling on either side while set
  bit          hold_req;        // asks the receiver for one long hold-off
  int          hold_left;
  int          stall_cnt;
  int          sent;

  conv2d_sliding_window u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tready(m_tready), .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // receiver side: check each output transaction, then pick next tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check('{m_tdata[9:0], m_tdata[19:10], m_tdata[59:20], m_tlast});
    if (rst) m_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      // long hold-off so the window queue fills and input backs up
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("conv2d_sliding_window verification failed");
      $finish;
    end
  end

  function automatic logic [40:0] weight_item(logic [c2d_pkg::WIDX_W-1:0] idx,
                                              logic [c2d_pkg::WGT_W-1:0] w);
    return {c2d_pkg::CMD_WEIGHT, 2'b00, 16'h0000, w, idx};
  endfunction

  function automatic logic [40:0] pixel_item(logic [c2d_pkg::PIX_W-1:0] p);
    // unused fields get random filler, the block must ignore them
    return {c2d_pkg::CMD_PIXEL, 2'b00, p, 16'($urandom), 6'($urandom)};
  endfunction

  // offer one input transaction; valid stays high into the next call
  task automatic send(logic [40:0] d);
    while (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= d[40];
    s_tdata <= d[39:0];
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(d);
    sent++;
  endtask

  // drop valid and wait out every owed result plus pipeline slack
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [10:0] size, logic [1:0] rad);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= c2d_pkg::REG_IMAGE_SIZE;
    cfg_data <= size;
    @(posedge clk);
    sb.write_reg(c2d_pkg::REG_IMAGE_SIZE, size);
    cfg_index <= c2d_pkg::REG_KERNEL_RADIUS;
    cfg_data <= {9'($urandom), rad};
    @(posedge clk);
    sb.write_reg(c2d_pkg::REG_KERNEL_RADIUS, rad);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int n, nk, npix;
    sb = new();
    sb.clear();
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_cnt = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: fill the whole kernel store first so no entry is read unloaded
    for (int i = 0; i < KSIDE_MAX*KSIDE_MAX; i++)
      send(weight_item(6'(i), (i % 2) ? 16'hffff : 16'h0000));
    send(weight_item(6'd63, 16'h1234));  // out-of-range index is dropped
    send(weight_item(6'd49, 16'hffff));
    // 3x3 image, 3x3 kernel: one result carrying frame_last
    set_regs(11'd3, 2'd1);
    send(pixel_item(16'h8000));
    send(pixel_item(16'h7fff));
    send(pixel_item(16'h8000));
    send(pixel_item(16'h7fff));
    send(pixel_item(16'h8000));
    send(pixel_item(16'h7fff));
    send(pixel_item(16'hffff));
    send(pixel_item(16'h0000));
    send(pixel_item(16'h8000));
    // image size zero acts as one: every pixel is a whole frame
    set_regs(11'd0, 2'd0);
    send(pixel_item(16'h7fff));
    send(pixel_item(16'h8000));
    // image smaller than kernel emits nothing but counters still wrap
    set_regs(11'd2, 2'd3);
    for (int i = 0; i < 6; i++) send(pixel_item(rand_pixel()));
    // oversized image saturates to the maximum, radius zero emits per pixel
    set_regs(11'd2047, 2'd0);
    for (int i = 0; i < 6; i++) send(pixel_item(rand_pixel()));

    // random phases over many register settings
    while (sent < 1900) begin
      case ($urandom_range(9))
        0: n = $urandom_range(1024, 2047);
        1: n = 0;
        2: n = $urandom_range(13, 40);
        default: n = $urandom_range(1, 12);
      endcase
      set_regs(11'(n), 2'($urandom));
      nk = $urandom_range(0, 8);
      for (int i = 0; i < nk; i++) send(weight_item(6'($urandom), 16'($urandom)));
      if (n == 0) npix = $urandom_range(1, 8);
      else if (n > 40) npix = $urandom_range(20, 60);
      else npix = (n * n) * $urandom_range(1, 3) + $urandom_range(0, n);
      if (npix > 400) npix = 400;
      calm = ($urandom_range(5) == 0);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(99) < 2) send(weight_item(6'($urandom), 16'($urandom)));
        send(pixel_item(rand_pixel()));
        if (sent > 900 && sent < 910 && hold_left == 0) hold_req = 1'b1;
        // one pause of the sender until every owed result is in
        if (i == npix / 2 && $urandom_range(7) == 0) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.owed_q.size() != 0) @(posedge clk);
        end
      end
      calm = 1'b0;
    end

    settle();
    if (sb.errors == 0 && sb.owed_q.size() == 0)
      $display("conv2d_sliding_window verification clean");
    else
      $display("conv2d_sliding_window verification failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/c2d_pkg.sv
hw/rtl/c2d_ram.sv
hw/rtl/c2d_front.sv
hw/rtl/c2d_back.sv
hw/rtl/conv2d_sliding_window.sv
tb/sv/conv2d_sliding_window_tb.sv
